// File: hw/rtl/cfdf_pkg.sv
// ----------------------------------------------------------------------------
// cfdf_pkg: shared types and constants of the command frame deframer
// result kinds, parser phases, result entry layout and header match step
// ----------------------------------------------------------------------------
package cfdf_pkg;

	localparam logic [7:0] CHAR_F = 8'h46;
	localparam logic [7:0] CHAR_5 = 8'h35;

	localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd127;

	localparam int unsigned HEAD_LEN = 8;
	localparam int unsigned TAIL_LEN = 8;

	// tail "55FF55FF", first byte at index 0
	localparam logic [7:0] TAIL_CHARS [TAIL_LEN] = '{
		CHAR_5, CHAR_5, CHAR_F, CHAR_F, CHAR_5, CHAR_5, CHAR_F, CHAR_F
	};

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_ACCEPT   = 2'd1,
		KIND_BAD_TAIL = 2'd2,
		KIND_TOO_LONG = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_HUNT         = 3'd0,
		PH_LEN          = 3'd1,
		PH_ID           = 3'd2,
		PH_PAYLOAD      = 3'd3,
		PH_TAIL         = 3'd4,
		PH_SKIP_PAYLOAD = 3'd5,
		PH_SKIP_TAIL    = 3'd6
	} phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic [7:0] frame_id;
		logic [7:0] frame_length;
	} entry_t;

	// next match length for header "FF55FF55" with overlap fallback
	function automatic logic [3:0] header_next(input logic [2:0] matched,
		input logic [7:0] c);
		logic [3:0] res;
		res = 4'd0;
		if (c == CHAR_F) begin
			case (matched)
				3'd0:    res = 4'd1;
				3'd1:    res = 4'd2;
				3'd2:    res = 4'd2;
				3'd3:    res = 4'd1;
				3'd4:    res = 4'd5;
				3'd5:    res = 4'd6;
				3'd6:    res = 4'd2;
				default: res = 4'd1;
			endcase
		end else if (c == CHAR_5) begin
			case (matched)
				3'd2:    res = 4'd3;
				3'd3:    res = 4'd4;
				3'd6:    res = 4'd7;
				3'd7:    res = 4'd8;
				default: res = 4'd0;
			endcase
		end
		return res;
	endfunction

endpackage

// File: hw/rtl/cfdf_front.sv
// ----------------------------------------------------------------------------
// cfdf_front: byte parser
// hunts for the header, tracks length, id, payload and tail, emits results
// ----------------------------------------------------------------------------
module cfdf_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  logic [7:0]      rx_byte,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata,
	output logic            res_valid,
	output cfdf_pkg::entry_t res_entry
);
	import cfdf_pkg::*;

	phase_t     phase_q, phase_d;
	logic [2:0] matched_q, matched_d;
	logic [7:0] length_q, length_d;
	logic [7:0] id_q, id_d;
	logic [7:0] count_q, count_d;
	logic [2:0] tidx_q, tidx_d;
	logic       tgood_q, tgood_d;
	logic [7:0] max_payload_q;
	logic [7:0] count_inc;
	logic [3:0] hnext;
	logic       tgood_now;

	assign count_inc = count_q + 8'd1;
	assign hnext     = header_next(matched_q, rx_byte);
	assign tgood_now = tgood_q & (rx_byte == TAIL_CHARS[tidx_q]);

	always_comb begin
		phase_d   = phase_q;
		matched_d = matched_q;
		length_d  = length_q;
		id_d      = id_q;
		count_d   = count_q;
		tidx_d    = tidx_q;
		tgood_d   = tgood_q;
		res_valid = 1'b0;
		res_entry.kind         = KIND_PAYLOAD;
		res_entry.payload_byte = 8'd0;
		res_entry.frame_id     = id_q;
		res_entry.frame_length = length_q;
		unique case (phase_q)
			PH_LEN: begin
				length_d = rx_byte;
				phase_d  = PH_ID;
			end
			PH_ID: begin
				id_d    = rx_byte;
				count_d = 8'd0;
				tidx_d  = 3'd0;
				tgood_d = 1'b1;
				if (length_q > max_payload_q) begin
					phase_d = PH_SKIP_PAYLOAD;
				end else if (length_q == 8'd0) begin
					phase_d = PH_TAIL;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				count_d = count_inc;
				if (count_inc >= length_q) begin
					phase_d = PH_TAIL;
				end
				res_valid = 1'b1;
				res_entry.payload_byte = rx_byte;
			end
			PH_SKIP_PAYLOAD: begin
				count_d = count_inc;
				if (count_inc >= length_q) begin
					phase_d = PH_SKIP_TAIL;
				end
			end
			PH_TAIL: begin
				tgood_d = tgood_now;
				if (tidx_q == 3'd7) begin
					tidx_d    = 3'd0;
					phase_d   = PH_HUNT;
					matched_d = 3'd0;
					res_valid = 1'b1;
					res_entry.kind = tgood_now ? KIND_ACCEPT : KIND_BAD_TAIL;
				end else begin
					tidx_d = tidx_q + 3'd1;
				end
			end
			PH_SKIP_TAIL: begin
				if (tidx_q == 3'd7) begin
					tidx_d    = 3'd0;
					phase_d   = PH_HUNT;
					matched_d = 3'd0;
					res_valid = 1'b1;
					res_entry.kind = KIND_TOO_LONG;
				end else begin
					tidx_d = tidx_q + 3'd1;
				end
			end
			default: begin
				// hunting, also taken by the unused phase code
				phase_d = PH_HUNT;
				if (hnext[3]) begin
					matched_d = 3'd0;
					phase_d   = PH_LEN;
				end else begin
					matched_d = hnext[2:0];
				end
			end
		endcase
		res_valid = res_valid & in_fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			matched_q     <= 3'd0;
			length_q      <= 8'd0;
			id_q          <= 8'd0;
			count_q       <= 8'd0;
			tidx_q        <= 3'd0;
			tgood_q       <= 1'b1;
			max_payload_q <= MAX_PAYLOAD_RESET;
		end else begin
			if (in_fire) begin
				phase_q   <= phase_d;
				matched_q <= matched_d;
				length_q  <= length_d;
				id_q      <= id_d;
				count_q   <= count_d;
				tidx_q    <= tidx_d;
				tgood_q   <= tgood_d;
			end
			if (cfg_we) begin
				max_payload_q <= cfg_wdata;
			end
		end
	end

endmodule

// File: hw/rtl/cfdf_queue.sv
// ----------------------------------------------------------------------------
// cfdf_queue: small result queue
// decouples the parser from the output stage
// ----------------------------------------------------------------------------
module cfdf_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  cfdf_pkg::entry_t wr_entry,
	input  logic             rd_en,
	output cfdf_pkg::entry_t rd_entry,
	output logic             not_empty,
	output logic             full
);
	import cfdf_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;

	assign rd_entry  = mem_q[rptr_q];
	assign not_empty = (cnt_q != '0);
	assign full      = (cnt_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (rd_en) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// File: hw/rtl/cfdf_back.sv
// ----------------------------------------------------------------------------
// cfdf_back: output stage
// pulls results from the queue into the output register and packs the bus
// ----------------------------------------------------------------------------
module cfdf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_not_empty,
	input  cfdf_pkg::entry_t q_entry,
	output logic             q_pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,
	output logic [1:0]       m_tuser
);
	import cfdf_pkg::*;

	entry_t out_q;
	logic   valid_q;

	assign q_pop    = q_not_empty && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign m_tdata  = {out_q.frame_length, out_q.frame_id, out_q.payload_byte};
	assign m_tuser  = out_q.kind;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= q_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// File: hw/rtl/command_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// command_frame_deframer_core: header/length/tail command frame parser
// one byte per transfer in, payload bytes and frame verdicts out
// ----------------------------------------------------------------------------
// path: a result is written into the queue on its input transfer, then moved into the output register
// throughput: one byte per cycle while the queue is not full, as the parser updates its state on every accepted byte
// a four-entry queue lets the input keep going while the output stalls, until the queue is full
// reset: asynchronous, active low; parser back to header hunt, max_payload 127,
// queue and output register empty
module command_frame_deframer_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side, one byte of the command stream per transfer
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// master side, one result per transfer
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] payload_byte, [15:8] frame_id, [23:16] frame_length
	output logic [1:0]  m_tuser,   // [1:0] kind
	// max_payload register write
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);
	import cfdf_pkg::*;

	logic   in_fire;
	logic   res_valid;
	entry_t res_entry;
	entry_t q_entry;
	logic   q_not_empty;
	logic   q_full;
	logic   q_pop;

	// take a byte whenever the queue has room for a possible result
	assign s_tready = !q_full;
	assign in_fire  = s_tvalid && s_tready;

	// front: header search and frame tracking, one byte per cycle while the queue has room
	cfdf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.rx_byte   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res_valid (res_valid),
		.res_entry (res_entry)
	);

	// queue between parser and output, absorbs output stalls
	cfdf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (res_valid),
		.wr_entry  (res_entry),
		.rd_en     (q_pop),
		.rd_entry  (q_entry),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	// back: output register feeding the master side
	cfdf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_entry     (q_entry),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

endmodule

// File: hw/rtl/cfdf_checker.sv
// ----------------------------------------------------------------------------
// cfdf_checker: port-level checks of the deframer
// output hold under stall, verdict payload field, input flow under drain
// ----------------------------------------------------------------------------
module cfdf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import cfdf_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// verdicts carry a zero payload byte
	a_verdict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_PAYLOAD) |-> (m_tdata[7:0] == 8'd0))
		else $error("verdict with nonzero payload byte");

	// a draining output keeps the input open
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		$past(m_tready) |-> s_tready)
		else $error("input blocked while output drains");

endmodule

bind command_frame_deframer_core cfdf_checker u_cfdf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser)
);
